### rtl/core/assert_macros.svh
// Concurrent assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/iqpu_pkg.sv
// Package: sizes, codes and controller/datapath interface types
package iqpu_pkg;

  localparam int ENTRIES     = 64;
  localparam int ID_BITS     = 16;
  localparam int PRIO_BITS   = 16;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int RAM_W       = ID_BITS + PRIO_BITS;
  localparam int IN_TDATA_W  = ((ID_BITS + PRIO_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ID_BITS + 7) / 8) * 8;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_POLL   = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;    // capture item, restart scan
    logic step;    // read one slot, advance scan address
    logic finish;  // commit table change, load result register
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;  // scan address at last slot
    logic out_free;   // result register can take a new result
  } dp_sts_t;

endpackage

### rtl/core/iqpu_ram.sv
// Generic single-write, single-read RAM with registered read data
module iqpu_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/iqpu_ctrl.sv
// Controller: sequences accept, table scan, drain and commit
module iqpu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  iqpu_pkg::dp_sts_t   sts,
  output iqpu_pkg::ctl_cmd_t  cmd
);
  import iqpu_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_SCAN: begin
        cmd.step = 1'b1;
      end
      S_DRAIN: begin
      end
      S_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/iqpu_dp.sv
// Datapath: valid bits, entry RAM, scan compare and result register
module iqpu_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_action,
  input  logic [iqpu_pkg::ID_BITS-1:0]      in_id,
  input  logic [iqpu_pkg::PRIO_BITS-1:0]    in_prio,
  input  iqpu_pkg::ctl_cmd_t                cmd,
  output iqpu_pkg::dp_sts_t                 sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [iqpu_pkg::ID_BITS-1:0]      out_id,
  output logic [1:0]                        out_status
);
  import iqpu_pkg::*;

  // captured item
  logic                 act_r;
  logic [ID_BITS-1:0]   id_r;
  logic [PRIO_BITS-1:0] prio_r;

  // scan
  logic [IDX_W-1:0]     addr_r;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     cmp_idx_r;

  // scan results
  logic                 hit_r;
  logic [IDX_W-1:0]     hit_idx_r;
  logic                 free_r;
  logic [IDX_W-1:0]     free_idx_r;
  logic                 best_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [ID_BITS-1:0]   best_id_r;
  logic [PRIO_BITS-1:0] best_prio_r;

  logic [ENTRIES-1:0]   valid_r;

  logic                 out_vld_r;
  logic [ID_BITS-1:0]   out_id_r;
  logic [1:0]           out_st_r;

  // RAM
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [RAM_W-1:0]     ram_rdata;
  logic [ID_BITS-1:0]   rd_id;
  logic [PRIO_BITS-1:0] rd_prio;
  logic                 rd_valid;
  logic                 better;

  assign rd_id    = ram_rdata[ID_BITS-1:0];
  assign rd_prio  = ram_rdata[ID_BITS +: PRIO_BITS];
  assign rd_valid = valid_r[cmp_idx_r];
  assign better   = !best_r || (rd_prio > best_prio_r) ||
                    ((rd_prio == best_prio_r) && (rd_id < best_id_r));

  assign ram_we    = cmd.finish && (act_r == ACT_UPDATE) && (hit_r || free_r);
  assign ram_waddr = hit_r ? hit_idx_r : free_idx_r;

  iqpu_ram #(
    .W (RAM_W),
    .D (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({prio_r, id_r}),
    .re    (cmd.step),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      id_r   <= in_id;
      prio_r <= in_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r    <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.step;
      if (cmd.load) begin
        addr_r <= '0;
      end else if (cmd.step) begin
        addr_r <= addr_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      best_r <= 1'b0;
    end else if (cmd.load) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      best_r <= 1'b0;
    end else if (cmp_vld_r) begin
      if (rd_valid && (rd_id == id_r) && !hit_r) begin
        hit_r <= 1'b1;
      end
      if (!rd_valid && !free_r) begin
        free_r <= 1'b1;
      end
      if (rd_valid && better) begin
        best_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld_r) begin
      if (rd_valid && (rd_id == id_r) && !hit_r) begin
        hit_idx_r <= cmp_idx_r;
      end
      if (!rd_valid && !free_r) begin
        free_idx_r <= cmp_idx_r;
      end
      if (rd_valid && better) begin
        best_idx_r  <= cmp_idx_r;
        best_id_r   <= rd_id;
        best_prio_r <= rd_prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.finish) begin
      if (act_r == ACT_POLL) begin
        if (best_r) begin
          valid_r[best_idx_r] <= 1'b0;
        end
      end else if (!hit_r && free_r) begin
        valid_r[free_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.finish) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (act_r == ACT_POLL) begin
        out_id_r <= best_r ? best_id_r : '0;
        out_st_r <= best_r ? STAT_OK : STAT_EMPTY;
      end else begin
        out_id_r <= '0;
        out_st_r <= (hit_r || free_r) ? STAT_OK : STAT_FULL;
      end
    end
  end

  assign sts.scan_last = (addr_r == IDX_W'(ENTRIES - 1));
  assign sts.out_free  = !out_vld_r || out_ready;

  assign out_valid  = out_vld_r;
  assign out_id     = out_id_r;
  assign out_status = out_st_r;

endmodule

### rtl/core/indexed_priority_queue_update_poll.sv
// Top level: indexed priority queue with update and poll items
//
//  channel | direction | tdata (low bit up)             | tuser
//  in_     | slave     | event_id, priority_req         | action
//  out_    | master    | polled_id                      | status
//
// One item passes through accept, one entry RAM read per slot, a drain step
// for the registered read and a commit step; a new item is taken only after
// the commit. The scan is serial as the entry RAM has a single read port.
// Reset clears every valid bit at once; the table is empty after reset.
// A finished result waits in the output register; the commit of the next
// item stalls only while that register is still held.
module indexed_priority_queue_update_poll (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [iqpu_pkg::IN_TDATA_W-1:0]    in_tdata,   // event_id, priority_req
  input  logic                               in_tuser,   // action
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [iqpu_pkg::OUT_TDATA_W-1:0]   out_tdata,  // polled_id
  output logic [1:0]                         out_tuser   // status
);
  import iqpu_pkg::*;

  `include "assert_macros.svh"

  ctl_cmd_t           cmd;
  dp_sts_t            sts;
  logic [ID_BITS-1:0] out_id;

  iqpu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iqpu_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_action  (in_tuser),
    .in_id      (in_tdata[ID_BITS-1:0]),
    .in_prio    (in_tdata[ID_BITS +: PRIO_BITS]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_id     (out_id),
    .out_status (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'(out_id);

  `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ASSERT_IMP(a_commit_needs_room, clk, rst_n, cmd.finish, sts.out_free)
  `ASSERT_NXT(a_commit_shows_result, clk, rst_n, cmd.finish, out_tvalid)
  `ASSERT_NXT(a_scan_stops, clk, rst_n, cmd.step && sts.scan_last, !cmd.step)

endmodule
